// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the key detector modules
// Each macro expects clk_i and rst_ni to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MKD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mkd assertion failed");

// Next-cycle implication.
`define MKD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mkd assertion failed");

`endif

// ===== hw/rtl/mkd_pkg.sv =====
// ----------------------------------------------------------------------------
// mkd_pkg
// Types, constants and helper functions of the musical key detector.
// ----------------------------------------------------------------------------
package mkd_pkg;

  localparam int unsigned ACT_W      = 2;
  localparam int unsigned NOTE_W     = 7;
  localparam int unsigned KEY_W      = 4;
  localparam int unsigned OPEN_W     = 7;
  localparam int unsigned SEEN_W     = 8;
  localparam int unsigned OPC_W      = 8;
  localparam int unsigned PC_N       = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_EN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_MAJOR   = 2'd2;

  localparam logic [OPEN_W-1:0] OPEN_LIMIT_RST = 7'd7;

  // Bit i holds template entry i.
  localparam logic [PC_N-1:0] DIATONIC_TPL = 12'b1010_1011_0101;
  localparam logic [PC_N-1:0] MAJOR_TPL    = 12'b0000_1001_0001;
  localparam logic [PC_N-1:0] MINOR_TPL    = 12'b0010_0001_0010;

  localparam logic [KEY_W-1:0] PC_LAST     = 4'd11;
  localparam logic [KEY_W-1:0] MINOR_SHIFT = 4'd3;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_REPORT = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  typedef struct packed {
    logic add_read;
    logic add_write;
    logic clear;
    logic scan_start;
    logic scan_read;
    logic step_start;
    logic pick_step;
    logic mode_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic note_ok;
    logic scan_last;
    logic step_last;
    logic out_free;
  } dp_sts_t;

  function automatic logic [KEY_W-1:0] add_mod12(input logic [KEY_W-1:0] a,
                                                 input logic [KEY_W-1:0] b);
    logic [KEY_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (KEY_W+1)'(PC_N)) begin
      s = s - (KEY_W+1)'(PC_N);
    end
    return s[KEY_W-1:0];
  endfunction

  // Template entry at pitch class (q + d) mod 12.
  function automatic logic tpl_bit(input logic [PC_N-1:0] tpl,
                                   input logic [KEY_W-1:0] q,
                                   input logic [KEY_W-1:0] d);
    logic [KEY_W-1:0] p;
    p = add_mod12(q, d);
    return tpl[p];
  endfunction

endpackage

// ===== hw/rtl/mkd_chan_if.sv =====
// ----------------------------------------------------------------------------
// mkd_chan_if
// Valid/ready channels carrying requests into and results out of the detector.
// ----------------------------------------------------------------------------
interface mkd_in_if;
  import mkd_pkg::*;

  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [NOTE_W-1:0] note_number;

  modport source (output valid, action, note_number, input ready);
  modport sink   (input valid, action, note_number, output ready);
endinterface

interface mkd_out_if;
  import mkd_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_offset;
  logic             is_major;

  modport source (output valid, key_offset, is_major, input ready);
  modport sink   (input valid, key_offset, is_major, output ready);
endinterface

// ===== hw/rtl/musical_key_detector.sv =====
// ----------------------------------------------------------------------------
// musical_key_detector
// Pitch-class template key detector built from a sequencer and a datapath.
// ----------------------------------------------------------------------------
// Requests arrive on in_i: action 0 adds a note, 1 asks for a key report,
// 2 clears both histograms and the note counter; action 3 is ignored.
// Only a report produces a result, delivered on out_o as key_offset and
// is_major. The configuration port is to get register writes only while
// idle; the block itself does not enforce this. An added note reads, then
// writes its histogram entry. A report scans every histogram entry once,
// one memory read per cycle, then finds the best rotation and scores the
// mode before the result register is loaded. The result sits in an output
// register; new requests are taken while it waits, and only a second report
// stalls once that register is still full.
// Reset empties both histograms at once through per-entry valid bits, so no
// clearing pass is needed, and restores the register defaults (opening
// limit 7, mode detection on, default major).
// ----------------------------------------------------------------------------
module musical_key_detector #(
  parameter int unsigned NOTE_RANGE = 128,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  mkd_in_if.sink                         in_i,
  mkd_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [mkd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mkd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import mkd_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  mkd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mkd_dp #(
    .NOTE_RANGE (NOTE_RANGE),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .in_note_i        (in_i.note_number),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .out_key_offset_o (out_o.key_offset),
    .out_is_major_o   (out_o.is_major)
  );

endmodule

// ===== hw/rtl/mkd_ctrl.sv =====
// ----------------------------------------------------------------------------
// mkd_ctrl
// Sequencer of the key detector: decodes requests and steps the datapath
// through note updates and the report scan, pick and mode phases.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mkd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [mkd_pkg::ACT_W-1:0] in_action_i,
  output logic                  in_ready_o,
  input  mkd_pkg::dp_sts_t      sts_i,
  output mkd_pkg::dp_cmd_t      cmd_o
);
  import mkd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_SCAN,
    S_DRAIN,
    S_PICK,
    S_MODE,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   in_fire;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (action_e'(in_action_i))
            ACT_ADD: begin
              // Notes outside the histogram range are dropped entirely.
              if (sts_i.note_ok) begin
                cmd_o.add_read = 1'b1;
                state_d        = S_ADD;
              end
            end
            ACT_REPORT: begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_SCAN;
            end
            ACT_CLEAR: begin
              cmd_o.clear = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_ADD: begin
        cmd_o.add_write = 1'b1;
        state_d         = S_IDLE;
      end
      S_SCAN: begin
        cmd_o.scan_read = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last read lands in the accumulators during this cycle.
        cmd_o.step_start = 1'b1;
        state_d          = S_PICK;
      end
      S_PICK: begin
        cmd_o.pick_step = 1'b1;
        if (sts_i.step_last) begin
          state_d = S_MODE;
        end
      end
      S_MODE: begin
        cmd_o.mode_step = 1'b1;
        if (sts_i.step_last) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `MKD_ASSERT_NEXT(a_report_busy, in_fire && (in_action_i == ACT_REPORT), !in_ready_o)
  `MKD_ASSERT_IMPL(a_load_when_free, cmd_o.out_load, sts_i.out_free)

endmodule

// ===== hw/rtl/mkd_dp.sv =====
// ----------------------------------------------------------------------------
// mkd_dp
// Datapath of the key detector: note and opening histogram memories,
// rotation score accumulators, winner search, mode decision and result
// register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mkd_dp #(
  parameter int unsigned NOTE_RANGE = 128,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mkd_pkg::dp_cmd_t              cmd_i,
  output mkd_pkg::dp_sts_t              sts_o,
  input  logic [mkd_pkg::NOTE_W-1:0]    in_note_i,
  input  logic                          cfg_we_i,
  input  logic [mkd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mkd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [mkd_pkg::KEY_W-1:0]     out_key_offset_o,
  output logic                          out_is_major_o
);
  import mkd_pkg::*;

  localparam int unsigned IDX_W   = $clog2(NOTE_RANGE);
  localparam int unsigned SCORE_W = COUNT_BITS + IDX_W;

  // Configuration registers.
  logic [OPEN_W-1:0] open_limit_q;
  logic              mode_en_q;
  logic              def_major_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_limit_q <= OPEN_LIMIT_RST;
      mode_en_q    <= 1'b1;
      def_major_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OPEN_LIMIT: open_limit_q <= cfg_data_i[OPEN_W-1:0];
        CFG_MODE_EN:    mode_en_q    <= cfg_data_i[0];
        CFG_DEF_MAJOR:  def_major_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Histogram memories with one valid bit per entry; clear drops all valid bits.
  logic [COUNT_BITS-1:0] note_mem [NOTE_RANGE];
  logic [OPEN_W-1:0]     open_mem [NOTE_RANGE];
  logic [NOTE_RANGE-1:0] ent_vld_q;

  logic [IDX_W-1:0]      addr_q;
  logic [IDX_W-1:0]      scan_addr_q;
  logic [KEY_W-1:0]      scan_pc_q;
  logic [IDX_W-1:0]      rd_addr;
  logic                  rd_en;
  logic [COUNT_BITS-1:0] note_rd_q;
  logic [OPEN_W-1:0]     open_rd_q;
  logic                  vld_rd_q;
  logic [COUNT_BITS-1:0] note_cur, note_new;
  logic [OPEN_W-1:0]     open_cur, open_new;
  logic [SEEN_W-1:0]     seen_q;

  assign rd_addr = cmd_i.add_read ? in_note_i[IDX_W-1:0] : scan_addr_q;
  assign rd_en   = cmd_i.add_read || cmd_i.scan_read;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      note_rd_q <= note_mem[rd_addr];
      open_rd_q <= open_mem[rd_addr];
      vld_rd_q  <= ent_vld_q[rd_addr];
    end
    if (cmd_i.add_write) begin
      note_mem[addr_q] <= note_new;
      open_mem[addr_q] <= open_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_read) begin
      addr_q <= in_note_i[IDX_W-1:0];
    end
  end

  assign note_cur = vld_rd_q ? note_rd_q : '0;
  assign open_cur = vld_rd_q ? open_rd_q : '0;
  assign note_new = (note_cur == '1) ? note_cur : note_cur + COUNT_BITS'(1);
  assign open_new = ((seen_q < {1'b0, open_limit_q}) && (open_cur != '1))
                    ? open_cur + OPEN_W'(1) : open_cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      seen_q    <= '0;
    end else if (cmd_i.clear) begin
      ent_vld_q <= '0;
      seen_q    <= '0;
    end else if (cmd_i.add_write) begin
      ent_vld_q[addr_q] <= 1'b1;
      if (seen_q != '1) begin
        seen_q <= seen_q + SEEN_W'(1);
      end
    end
  end

  // Scan address and its pitch class advance together.
  logic             acc_vld_q;
  logic [KEY_W-1:0] acc_pc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_addr_q <= '0;
      scan_pc_q   <= '0;
      acc_vld_q   <= 1'b0;
    end else begin
      acc_vld_q <= cmd_i.scan_read;
      if (cmd_i.scan_start) begin
        scan_addr_q <= '0;
        scan_pc_q   <= '0;
      end else if (cmd_i.scan_read) begin
        scan_addr_q <= scan_addr_q + IDX_W'(1);
        scan_pc_q   <= (scan_pc_q == PC_LAST) ? '0 : scan_pc_q + KEY_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_read) begin
      acc_pc_q <= scan_pc_q;
    end
  end

  // Per-rotation diatonic scores and per-pitch-class opening counts. The
  // opening total never exceeds 127, so the pitch-class sums cannot overflow.
  logic [SCORE_W-1:0] score_q [PC_N];
  logic [OPC_W-1:0]   opc_q   [PC_N];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < PC_N; k++) begin
      if (cmd_i.scan_start) begin
        score_q[k] <= '0;
        opc_q[k]   <= '0;
      end else if (acc_vld_q) begin
        if (tpl_bit(DIATONIC_TPL, acc_pc_q, KEY_W'(k))) begin
          score_q[k] <= score_q[k] + SCORE_W'(note_cur);
        end
        if (acc_pc_q == KEY_W'(k)) begin
          opc_q[k] <= opc_q[k] + OPC_W'(open_cur);
        end
      end
    end
  end

  // Shared step counter for the winner search and the mode pass.
  logic [KEY_W-1:0]   step_q;
  logic               step_last;
  logic [SCORE_W-1:0] best_q;
  logic [KEY_W-1:0]   best_d_q;
  logic [SCORE_W-1:0] score_sel;
  logic [OPC_W-1:0]   opc_sel;
  logic [OPC_W-1:0]   maj_q, min_q;

  assign step_last = (step_q == PC_LAST);
  assign score_sel = score_q[step_q];
  assign opc_sel   = opc_q[step_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.step_start) begin
      step_q <= '0;
    end else if (cmd_i.pick_step || cmd_i.mode_step) begin
      step_q <= step_last ? '0 : step_q + KEY_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_start) begin
      maj_q <= '0;
      min_q <= '0;
    end
    if (cmd_i.pick_step) begin
      // Strictly greater keeps the lowest rotation on ties.
      if ((step_q == '0) || (score_sel > best_q)) begin
        best_q   <= score_sel;
        best_d_q <= step_q;
      end
    end
    if (cmd_i.mode_step) begin
      if (tpl_bit(MAJOR_TPL, step_q, best_d_q)) begin
        maj_q <= maj_q + opc_sel;
      end
      if (tpl_bit(MINOR_TPL, step_q, best_d_q)) begin
        min_q <= min_q + opc_sel;
      end
    end
  end

  // Result register.
  logic             res_major;
  logic [KEY_W-1:0] res_key;
  logic             out_vld_q;
  logic [KEY_W-1:0] out_key_q;
  logic             out_major_q;

  assign res_major = def_major_q && !(mode_en_q && (maj_q < min_q));
  assign res_key   = res_major ? best_d_q : add_mod12(best_d_q, MINOR_SHIFT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_key_q   <= res_key;
      out_major_q <= res_major;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign out_key_offset_o = out_key_q;
  assign out_is_major_o   = out_major_q;

  assign sts_o.note_ok   = ({1'b0, in_note_i} < (NOTE_W+1)'(NOTE_RANGE));
  assign sts_o.scan_last = (scan_addr_q == IDX_W'(NOTE_RANGE - 1));
  assign sts_o.step_last = step_last;
  assign sts_o.out_free  = !out_vld_q || out_ready_i;

  `MKD_ASSERT_IMPL(a_scan_pc_range, 1'b1, scan_pc_q < KEY_W'(PC_N))
  `MKD_ASSERT_NEXT(a_acc_follows_read, cmd_i.scan_read, acc_vld_q)
  `MKD_ASSERT_IMPL(a_out_key_range, out_vld_q, out_key_q < KEY_W'(PC_N))

endmodule

// ===== verif/musical_key_detector_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// musical_key_detector_tb
// Self-checking bench for the key detector. Note, report, clear and unused
// requests are driven with random gaps, and reports are scored against a
// pitch-class template predictor kept in a scoreboard. It also covers
// saturation of the note counter and several register settings.
// ----------------------------------------------------------------------------

localparam int unsigned NOTE_SPAN  = 128;
localparam int unsigned PC_COUNT   = 12;

// Bit i holds template entry i.
localparam bit [11:0] SCALE_MASK = 12'b1010_1011_0101;
localparam bit [11:0] MAJOR_MASK = 12'b0000_1001_0001;
localparam bit [11:0] MINOR_MASK = 12'b0010_0001_0010;

typedef struct packed {
  logic [3:0] key_offset;
  logic       is_major;
} key_result_t;

class key_scoreboard;
  bit [15:0]   note_count [NOTE_SPAN];
  bit [6:0]    opening_count [NOTE_SPAN];
  bit [7:0]    notes_added;
  bit [6:0]    opening_limit;
  bit          mode_detect;
  bit          default_major;
  key_result_t expected_keys [$];
  int unsigned mismatches;
  int unsigned reports_checked;

  function new();
    clear_counts();
    opening_limit   = 7'd7;
    mode_detect     = 1'b1;
    default_major   = 1'b1;
    mismatches      = 0;
    reports_checked = 0;
  endfunction

  function void clear_counts();
    foreach (note_count[i]) begin
      note_count[i]    = '0;
      opening_count[i] = '0;
    end
    notes_added = '0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [6:0] data);
    case (idx)
      mkd_pkg::CFG_OPEN_LIMIT: opening_limit = data;
      mkd_pkg::CFG_MODE_EN:    mode_detect   = data[0];
      mkd_pkg::CFG_DEF_MAJOR:  default_major = data[0];
      default: ;
    endcase
  endfunction

  function key_result_t predict_key();
    key_result_t res;
    bit [63:0]   score;
    bit [63:0]   best_score;
    bit [63:0]   major_score;
    bit [63:0]   minor_score;
    int unsigned best_rot;
    int unsigned pc;
    bit          major;
    best_score = '0;
    best_rot   = 0;
    for (int unsigned d = 0; d < PC_COUNT; d++) begin
      score = '0;
      for (int unsigned x = 0; x < NOTE_SPAN; x++) begin
        if (SCALE_MASK[(x + d) % PC_COUNT]) score += note_count[x];
      end
      if (d == 0 || score > best_score) begin
        best_score = score;
        best_rot   = d;
      end
    end
    major = default_major;
    if (mode_detect) begin
      major_score = '0;
      minor_score = '0;
      for (int unsigned x = 0; x < NOTE_SPAN; x++) begin
        pc = (x + best_rot) % PC_COUNT;
        if (MAJOR_MASK[pc]) major_score += opening_count[x];
        if (MINOR_MASK[pc]) minor_score += opening_count[x];
      end
      if (major_score < minor_score) major = 1'b0;
    end
    // A minor key is named from its relative major, three semitones up.
    if (!major) best_rot = (best_rot + 3) % PC_COUNT;
    res.key_offset = 4'(best_rot);
    res.is_major   = major;
    return res;
  endfunction

  function void note_request(logic [1:0] act, logic [6:0] note);
    case (act)
      mkd_pkg::ACT_ADD: begin
        if (note_count[note] != 16'hFFFF) note_count[note]++;
        if ({1'b0, notes_added} < {2'b00, opening_limit} && opening_count[note] != 7'h7F) begin
          opening_count[note]++;
        end
        if (notes_added != 8'hFF) notes_added++;
      end
      mkd_pkg::ACT_CLEAR:  clear_counts();
      mkd_pkg::ACT_REPORT: expected_keys.push_back(predict_key());
      default: ;
    endcase
  endfunction

  function void check_result(logic [3:0] key_offset, logic is_major);
    key_result_t exp_key;
    if (expected_keys.size() == 0) begin
      $error("unexpected result: key_offset=%0d is_major=%0d", key_offset, is_major);
      mismatches++;
      return;
    end
    exp_key = expected_keys.pop_front();
    reports_checked++;
    if (key_offset !== exp_key.key_offset) begin
      $error("key_offset mismatch: expected %0d, actual %0d", exp_key.key_offset, key_offset);
      mismatches++;
    end
    if (is_major !== exp_key.is_major) begin
      $error("is_major mismatch: expected %0d, actual %0d", exp_key.is_major, is_major);
      mismatches++;
    end
  endfunction

  function int unsigned pending();
    return expected_keys.size();
  endfunction
endclass

module musical_key_detector_tb;
  import mkd_pkg::*;

  localparam logic [ACT_W-1:0]     ACT_IGNORED   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED    = 2'd3;
  localparam int unsigned          SETTLE_CYCLES = NOTE_SPAN + 40;
  localparam int unsigned          CYCLE_LIMIT   = 3_000_000;
  localparam int unsigned          RANDOM_ITEMS  = 1650;
  localparam int unsigned          NUM_PHASES    = 8;
  // Two lead notes plus these and the tail notes carry the note counter past 255.
  localparam int unsigned          LEAD_ADDS     = 198;
  localparam int unsigned          TAIL_ADDS     = 70;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  mkd_in_if  in_if ();
  mkd_out_if out_if ();

  musical_key_detector i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  key_scoreboard sb;
  int unsigned   cycles = 0;
  int unsigned   requests_sent = 0;
  int unsigned   random_sent = 0;
  int unsigned   settings_used = 0;
  bit            src_idle = 1'b1;
  bit            snk_idle = 1'b1;
  int unsigned   scale_steps [7] = '{0, 2, 4, 5, 7, 9, 11};

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random back-pressure, every accepted result goes to the checker.
  initial begin
    int unsigned stall;
    forever begin
      stall = snk_idle ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid === 1'b1 && out_if.ready));
      sb.check_result(out_if.key_offset, out_if.is_major);
    end
  end

  task automatic send_request(logic [ACT_W-1:0] act, logic [NOTE_W-1:0] note);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.action      <= act;
    in_if.note_number <= note;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.note_request(act, note);
    requests_sent++;
  endtask

  // Drains all reports, then gives a trailing note update time to land.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_regs(logic [6:0] limit, logic mode_en, logic def_major);
    logic [6:0] junk;
    junk = 7'($urandom);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_OPEN_LIMIT;
    cfg_data_i <= limit;
    @(posedge clk_i);
    sb.write_reg(CFG_OPEN_LIMIT, limit);
    cfg_idx_i  <= CFG_MODE_EN;
    cfg_data_i <= {6'b0, mode_en};
    @(posedge clk_i);
    sb.write_reg(CFG_MODE_EN, {6'b0, mode_en});
    cfg_idx_i  <= CFG_DEF_MAJOR;
    cfg_data_i <= {6'b0, def_major};
    @(posedge clk_i);
    sb.write_reg(CFG_DEF_MAJOR, {6'b0, def_major});
    // The unused index must not disturb any register.
    cfg_idx_i  <= CFG_UNUSED;
    cfg_data_i <= junk;
    @(posedge clk_i);
    sb.write_reg(CFG_UNUSED, junk);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // One short piece: mostly a clear, chord tones first so the opening notes
  // lean major or minor, then scale tones, some noise, and a closing report.
  task automatic play_phrase();
    int unsigned len;
    int unsigned root;
    int unsigned tonic;
    int unsigned pc;
    int unsigned octave;
    int unsigned roll;
    int unsigned chord [3];
    bit          minor;
    logic [6:0]  note;
    src_idle = ($urandom_range(0, 3) != 0);
    snk_idle = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 9) != 0) begin
      send_request(ACT_CLEAR, 7'($urandom));
      random_sent++;
    end
    root  = $urandom_range(0, 11);
    minor = 1'($urandom_range(0, 1));
    tonic = minor ? (root + 3) % PC_COUNT : root;
    chord = '{0, minor ? 3 : 4, 7};
    len   = ($urandom_range(0, 19) == 0) ? $urandom_range(128, 300) : $urandom_range(0, 24);
    for (int unsigned i = 0; i < len; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        send_request(ACT_IGNORED, 7'($urandom));
      end else if (roll < 6) begin
        send_request(ACT_REPORT, 7'($urandom));
      end else if (roll < 12) begin
        send_request(ACT_ADD, 7'($urandom));
      end else begin
        if (i < 4) pc = (root + chord[$urandom_range(0, 2)]) % PC_COUNT;
        else pc = (tonic + scale_steps[$urandom_range(0, 6)]) % PC_COUNT;
        octave = $urandom_range(0, 10);
        if (octave * 12 + pc > 127) octave = 9;
        note = 7'(octave * 12 + pc);
        send_request(ACT_ADD, note);
      end
      random_sent++;
    end
    send_request(ACT_REPORT, 7'($urandom));
    random_sent++;
  endtask

  initial begin
    int unsigned budget;
    logic [6:0]  lim;
    logic        mode_en;
    logic        def_major;
    sb = new();
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.action      <= ACT_ADD;
    in_if.note_number <= '0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= CFG_OPEN_LIMIT;
    cfg_data_i        <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests at the reset settings.
    send_request(ACT_REPORT, 7'd0);     // empty histograms
    send_request(ACT_IGNORED, 7'd127);
    send_request(ACT_ADD, 7'd127);
    send_request(ACT_ADD, 7'd0);
    send_request(ACT_ADD, 7'd60);
    send_request(ACT_ADD, 7'd64);
    send_request(ACT_ADD, 7'd67);
    send_request(ACT_REPORT, 7'd127);
    send_request(ACT_CLEAR, 7'd127);
    send_request(ACT_REPORT, 7'd0);
    send_request(ACT_ADD, 7'd57);
    send_request(ACT_ADD, 7'd60);
    send_request(ACT_ADD, 7'd64);
    send_request(ACT_ADD, 7'd69);
    send_request(ACT_ADD, 7'd72);
    send_request(ACT_REPORT, 7'd85);
    send_request(ACT_IGNORED, 7'd0);
    send_request(ACT_REPORT, 7'd42);    // state must be unchanged
    send_request(ACT_ADD, 7'd85);
    send_request(ACT_ADD, 7'd42);
    send_request(ACT_REPORT, 7'd0);
    send_request(ACT_CLEAR, 7'd0);
    settle();

    // Note counter saturation: two neutral opening notes, then enough notes
    // to pass 255. If the counter wrapped, the closing notes on class 9 would
    // enter the opening counts and turn the reported mode to minor.
    program_regs(7'd2, 1'b1, 1'b1);
    src_idle = 1'b0;
    snk_idle = 1'b0;
    send_request(ACT_CLEAR, 7'd0);
    repeat (2) send_request(ACT_ADD, 7'd2);
    repeat (LEAD_ADDS) send_request(ACT_ADD, 7'd0);
    repeat (TAIL_ADDS) send_request(ACT_ADD, 7'd9);
    send_request(ACT_REPORT, 7'd0);
    settle();

    budget = RANDOM_ITEMS / NUM_PHASES;
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       begin lim = 7'd0;   mode_en = 1'b1; def_major = 1'b1; end
        1:       begin lim = 7'd127; mode_en = 1'b1; def_major = 1'b0; end
        2:       begin lim = 7'd1;   mode_en = 1'b0; def_major = 1'b0; end
        3:       begin lim = 7'd127; mode_en = 1'b0; def_major = 1'b1; end
        4:       begin lim = 7'd7;   mode_en = 1'b1; def_major = 1'b0; end
        default: begin
          lim       = 7'($urandom_range(0, 127));
          mode_en   = 1'($urandom_range(0, 1));
          def_major = 1'($urandom_range(0, 1));
        end
      endcase
      program_regs(lim, mode_en, def_major);
      random_sent = 0;
      while (random_sent < budget) play_phrase();
      settle();
    end

    $display("Sent %0d requests over %0d register settings, including counter saturation.",
             requests_sent, settings_used);
    $display("Checked %0d key reports, %0d mismatches.", sb.reports_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
